@@ rtl/sfe_pkg.sv @@
package sfe_pkg;

	typedef struct packed {
		logic [7:0]  body_byte;
		logic        frame_start;
		logic        frame_end;
		logic [15:0] body_length;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
	} result_t;

	localparam int KeyIdxW = 4;
	localparam int SeqIdxW = 4;

	// Precomputed wire bytes of one item, held until the last one has been sent.
	typedef struct packed {
		logic [15:0] body_length;
		logic [7:0]  body_x;
		logic [7:0]  crc_lo_x;
		logic [7:0]  crc_hi_x;
	} frame_bytes_t;

	// State that the next item continues from.
	typedef struct packed {
		logic [15:0]        crc;
		logic [KeyIdxW-1:0] key_pos;
	} enc_state_t;

	localparam logic [15:0] CrcPoly    = 16'h1021;
	localparam logic [7:0]  HdrByte0   = 8'hAB;
	localparam logic [7:0]  HdrByte1   = 8'hCD;
	localparam logic [7:0]  TrlByte0   = 8'hDC;
	localparam logic [7:0]  TrlByte1   = 8'hBA;

	// Positions within the byte sequence that one item can produce.
	localparam logic [SeqIdxW-1:0] SEQ_HDR0   = 4'd0;
	localparam logic [SeqIdxW-1:0] SEQ_HDR1   = 4'd1;
	localparam logic [SeqIdxW-1:0] SEQ_LEN_LO = 4'd2;
	localparam logic [SeqIdxW-1:0] SEQ_LEN_HI = 4'd3;
	localparam logic [SeqIdxW-1:0] SEQ_BODY   = 4'd4;
	localparam logic [SeqIdxW-1:0] SEQ_CRC_LO = 4'd5;
	localparam logic [SeqIdxW-1:0] SEQ_CRC_HI = 4'd6;
	localparam logic [SeqIdxW-1:0] SEQ_TRL0   = 4'd7;
	localparam logic [SeqIdxW-1:0] SEQ_TRL1   = 4'd8;

	localparam logic [7:0] KeyStream [16] = '{
		8'h16, 8'h6c, 8'h14, 8'he6, 8'h2e, 8'h91, 8'h0d, 8'h40,
		8'h21, 8'h35, 8'hd5, 8'h40, 8'h13, 8'h03, 8'he9, 8'h80
	};

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/sfe_calc.sv @@
module sfe_calc #(
	parameter int KEY_LENGTH = 16
) (
	input  sfe_pkg::item_t      item,
	input  sfe_pkg::enc_state_t cur,
	output sfe_pkg::frame_bytes_t bytes,
	output sfe_pkg::enc_state_t nxt
);

	localparam logic [sfe_pkg::KeyIdxW:0] KeyLen = (sfe_pkg::KeyIdxW+1)'(KEY_LENGTH);

	logic [15:0]                 crc_base;
	logic [15:0]                 crc_new;
	logic [sfe_pkg::KeyIdxW-1:0] pos0;
	logic [sfe_pkg::KeyIdxW-1:0] pos1;
	logic [sfe_pkg::KeyIdxW-1:0] pos2;
	logic [sfe_pkg::KeyIdxW-1:0] pos3;

	function automatic logic [sfe_pkg::KeyIdxW-1:0] pos_inc(
		input logic [sfe_pkg::KeyIdxW-1:0] p
	);
		logic [sfe_pkg::KeyIdxW:0] n;
		n = {1'b0, p} + 1'b1;
		return (n >= KeyLen) ? '0 : n[sfe_pkg::KeyIdxW-1:0];
	endfunction

	// A start mark restarts the CRC and the keystream before this byte.
	assign crc_base = item.frame_start ? 16'h0000 : cur.crc;
	assign pos0     = item.frame_start ? '0 : cur.key_pos;
	assign pos1     = pos_inc(pos0);
	assign pos2     = pos_inc(pos1);
	assign pos3     = pos_inc(pos2);
	assign crc_new  = sfe_pkg::crc_byte(crc_base, item.body_byte);

	assign bytes.body_length = item.body_length;
	assign bytes.body_x      = item.body_byte ^ sfe_pkg::KeyStream[pos0];
	assign bytes.crc_lo_x    = crc_new[7:0] ^ sfe_pkg::KeyStream[pos1];
	assign bytes.crc_hi_x    = crc_new[15:8] ^ sfe_pkg::KeyStream[pos2];

	assign nxt.crc     = crc_new;
	assign nxt.key_pos = item.frame_end ? pos3 : pos1;

endmodule

@@ rtl/serial_frame_encoder_crc_xor.sv @@
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      sfe_pkg::item_t
// result    out        result_valid / result_ready  sfe_pkg::result_t
//
// A body byte is taken in one handshake; CRC and keystream work finish at acceptance.
// The item then yields 1, 5, 5 or 9 output bytes, one byte per cycle unless stalled,
// so a mid-frame byte yields one output byte and only frame edges add header or trailer bytes.
// The next item is taken in the same cycle that the last byte of the current one leaves.
// Reset clears the CRC, the key position and the output valid flag.
// A stalled output holds its byte and blocks new items until its last byte leaves.
module serial_frame_encoder_crc_xor #(
	parameter int KEY_LENGTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  sfe_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output sfe_pkg::result_t result
);

	sfe_pkg::enc_state_t   state_q;
	sfe_pkg::enc_state_t   state_nxt;
	sfe_pkg::frame_bytes_t bytes_c;
	sfe_pkg::frame_bytes_t bytes_q;
	logic                  valid_q;
	logic [sfe_pkg::SeqIdxW-1:0] idx_q;
	logic [sfe_pkg::SeqIdxW-1:0] last_q;
	logic                  on_last;
	logic                  accept;

	sfe_calc #(
		.KEY_LENGTH(KEY_LENGTH)
	) u_calc (
		.item (item),
		.cur  (state_q),
		.bytes(bytes_c),
		.nxt  (state_nxt)
	);

	assign on_last    = (idx_q == last_q);
	assign item_ready = !valid_q || (result_ready && on_last);
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= sfe_pkg::SEQ_BODY;
			last_q  <= sfe_pkg::SEQ_BODY;
			state_q <= '0;
		end else begin
			if (accept) begin
				valid_q <= 1'b1;
				idx_q   <= item.frame_start ? sfe_pkg::SEQ_HDR0 : sfe_pkg::SEQ_BODY;
				last_q  <= item.frame_end ? sfe_pkg::SEQ_TRL1 : sfe_pkg::SEQ_BODY;
				state_q <= state_nxt;
			end else if (valid_q && result_ready) begin
				if (on_last) begin
					valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_q <= bytes_c;
		end
	end

	assign result_valid      = valid_q;
	assign result.run_last   = on_last;
	assign result.frame_done = (idx_q == sfe_pkg::SEQ_TRL1);

	always_comb begin
		unique case (idx_q)
			sfe_pkg::SEQ_HDR0:   result.out_byte = sfe_pkg::HdrByte0;
			sfe_pkg::SEQ_HDR1:   result.out_byte = sfe_pkg::HdrByte1;
			sfe_pkg::SEQ_LEN_LO: result.out_byte = bytes_q.body_length[7:0];
			sfe_pkg::SEQ_LEN_HI: result.out_byte = bytes_q.body_length[15:8];
			sfe_pkg::SEQ_BODY:   result.out_byte = bytes_q.body_x;
			sfe_pkg::SEQ_CRC_LO: result.out_byte = bytes_q.crc_lo_x;
			sfe_pkg::SEQ_CRC_HI: result.out_byte = bytes_q.crc_hi_x;
			sfe_pkg::SEQ_TRL0:   result.out_byte = sfe_pkg::TrlByte0;
			sfe_pkg::SEQ_TRL1:   result.out_byte = sfe_pkg::TrlByte1;
			default:             result.out_byte = 8'h00;
		endcase
	end

	// The sequence index never runs past the last byte of its transaction.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= last_q))
		else $error("sequence index beyond last byte");

	// A frame start always opens its output with the first header byte.
	a_hdr_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.frame_start) |=> (result_valid && result.out_byte == sfe_pkg::HdrByte0))
		else $error("frame start did not emit header");

	// The trailer end byte always closes the transaction.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_done) |-> (result.run_last && item_ready == result_ready))
		else $error("frame done not on last byte");

	// A body-only transaction leaves after a single handshake.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !item.frame_start && !item.frame_end) |=> (result_valid && result.run_last))
		else $error("plain body byte produced more than one byte");

endmodule

@@ test/frame_stream_checker.sv @@
`timescale 1ns / 100ps

module frame_stream_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  sfe_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  sfe_pkg::result_t result,
	output int               fail_count,
	output int               pending
);
	import sfe_pkg::*;

	localparam int          KeyLen     = 16;
	localparam logic [15:0] XmodemPoly = 16'h1021;
	localparam logic [7:0]  SyncMark0  = 8'hAB;
	localparam logic [7:0]  SyncMark1  = 8'hCD;
	localparam logic [7:0]  TailMark0  = 8'hDC;
	localparam logic [7:0]  TailMark1  = 8'hBA;

	result_t     wire_bytes[$];
	logic [15:0] crc_acc;
	logic [3:0]  key_idx;
	int          results_seen;

	initial begin
		fail_count = 0;
		pending = 0;
		results_seen = 0;
		crc_acc = '0;
		key_idx = '0;
	end

	function automatic logic [7:0] key_at(input logic [3:0] idx);
		case (idx)
			4'd0:  return 8'h16;
			4'd1:  return 8'h6c;
			4'd2:  return 8'h14;
			4'd3:  return 8'he6;
			4'd4:  return 8'h2e;
			4'd5:  return 8'h91;
			4'd6:  return 8'h0d;
			4'd7:  return 8'h40;
			4'd8:  return 8'h21;
			4'd9:  return 8'h35;
			4'd10: return 8'hd5;
			4'd11: return 8'h40;
			4'd12: return 8'h13;
			4'd13: return 8'h03;
			4'd14: return 8'he9;
			default: return 8'h80;
		endcase
	endfunction

	// Bit-serial form of CRC-16/XMODEM, most significant data bit first.
	function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] acc;
		acc = crc;
		for (int b = 7; b >= 0; b--) begin
			if (acc[15] ^ data[b]) begin
				acc = {acc[14:0], 1'b0} ^ XmodemPoly;
			end else begin
				acc = {acc[14:0], 1'b0};
			end
		end
		return acc;
	endfunction

	function automatic logic [7:0] take_key();
		logic [7:0] k;
		k = key_at(key_idx);
		key_idx = (key_idx == KeyLen - 1) ? 4'd0 : key_idx + 4'd1;
		return k;
	endfunction

	task automatic push_wire(input logic [7:0] b, input logic last, input logic done);
		result_t r;
		r.out_byte = b;
		r.run_last = last;
		r.frame_done = done;
		wire_bytes.push_back(r);
	endtask

	task automatic predict_wire_bytes(input item_t it);
		logic [7:0] body_x;
		logic [7:0] crc_lo_x;
		logic [7:0] crc_hi_x;
		if (it.frame_start) begin
			crc_acc = '0;
			key_idx = '0;
			push_wire(SyncMark0, 1'b0, 1'b0);
			push_wire(SyncMark1, 1'b0, 1'b0);
			push_wire(it.body_length[7:0], 1'b0, 1'b0);
			push_wire(it.body_length[15:8], 1'b0, 1'b0);
		end
		crc_acc = crc_xmodem_step(crc_acc, it.body_byte);
		body_x = it.body_byte ^ take_key();
		push_wire(body_x, !it.frame_end, 1'b0);
		if (it.frame_end) begin
			// The CRC bytes take the key positions right after the last body byte.
			crc_lo_x = crc_acc[7:0] ^ take_key();
			crc_hi_x = crc_acc[15:8] ^ take_key();
			push_wire(crc_lo_x, 1'b0, 1'b0);
			push_wire(crc_hi_x, 1'b0, 1'b0);
			push_wire(TailMark0, 1'b0, 1'b0);
			push_wire(TailMark1, 1'b1, 1'b1);
		end
	endtask

	task automatic report(input string what);
		fail_count++;
		$display("mismatch at output byte %0d: %s", results_seen, what);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (wire_bytes.size() == 0) begin
			report($sformatf("byte %02h arrived with nothing pending", got.out_byte));
		end else begin
			want = wire_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
			end
			if (got.run_last !== want.run_last) begin
				report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
			end
			if (got.frame_done !== want.frame_done) begin
				report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
			end
		end
		results_seen++;
	endtask

	// Results leave only after the item that causes them, so the output side is
	// checked before the accepted input adds its bytes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc = '0;
			key_idx = '0;
			wire_bytes.delete();
		end else begin
			if (result_valid && result_ready) begin
				check_result(result);
			end
			if (item_valid && item_ready) begin
				predict_wire_bytes(item);
			end
		end
		pending <= wire_bytes.size();
	end

endmodule

@@ test/tb_serial_frame_encoder_crc_xor.sv @@
`timescale 1ns / 100ps

module tb_serial_frame_encoder_crc_xor;
	import sfe_pkg::*;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE
	} ready_mode_e;

	localparam int RandomItems = 400;
	localparam int DrainLimit  = 20000;
	localparam int SettleTicks = 20;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	int          fail_count;
	int          pending;
	int          items_sent = 0;
	int          burst_left = 0;
	ready_mode_e ready_mode = READY_ALWAYS;
	int          ready_left = 0;

	always #5 clk = ~clk;

	serial_frame_encoder_crc_xor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	frame_stream_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// The receiver switches between runs of full speed, coin-flip stalls and
	// heavy stalls, independent of what the block is doing.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_e'($urandom_range(0, 2));
			ready_left = $urandom_range(4, 60);
		end
		ready_left--;
		case (ready_mode)
			READY_ALWAYS: result_ready <= 1'b1;
			READY_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
			default:      result_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic item_t make_item(input logic [7:0] b, input logic s, input logic e,
			input logic [15:0] len);
		item_t it;
		it.body_byte = b;
		it.frame_start = s;
		it.frame_end = e;
		it.body_length = len;
		return it;
	endfunction

	// Valid stays high across a burst; a gap is only opened once a burst is over.
	task automatic send_item(input item_t it);
		int gap;
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		int          frame_len;
		logic [15:0] hdr_len;
		logic        mark_start;
		logic        mark_end;
		int          drain_wait;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A byte without marks carries on from the reset state.
		send_item(make_item(8'h00, 1'b0, 1'b0, 16'h0000));
		// Frame end without a start closes out whatever ran since reset.
		send_item(make_item(8'hFF, 1'b0, 1'b1, 16'hFFFF));
		// Both marks on one byte make a one-byte frame; a zero length goes out as is.
		send_item(make_item(8'hA5, 1'b1, 1'b1, 16'h0000));
		// This frame is cut short by the next start.
		send_item(make_item(8'h00, 1'b1, 1'b0, 16'hFFFF));
		send_item(make_item(8'hFF, 1'b0, 1'b0, 16'h5A5A));
		send_item(make_item(8'h80, 1'b0, 1'b0, 16'h0000));
		// Seventeen bytes wrap the key position before the CRC bytes.
		for (int i = 0; i < 17; i++) begin
			send_item(make_item(8'(i * 31 + 1), i == 0, i == 16, 16'd17));
		end

		while (items_sent < RandomItems) begin
			if ($urandom_range(0, 7) == 0) begin
				send_item(make_item(8'($urandom), 1'b0, 1'b0, 16'($urandom)));
			end
			frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
				: $urandom_range(1, 16);
			hdr_len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(frame_len);
			for (int i = 0; i < frame_len; i++) begin
				mark_start = (i == 0);
				mark_end = (i == frame_len - 1);
				if ($urandom_range(0, 24) == 0) begin
					mark_start = ~mark_start;
				end
				if ($urandom_range(0, 24) == 0) begin
					mark_end = ~mark_end;
				end
				send_item(make_item(8'($urandom), mark_start, mark_end,
					mark_start ? hdr_len : 16'($urandom)));
			end
		end
		item_valid <= 1'b0;
		// The pending count is a registered copy of the checker's queue, so wait for it to take in the last transaction.
		@(posedge clk);

		drain_wait = 0;
		while (pending != 0 && drain_wait < DrainLimit) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (SettleTicks) @(posedge clk);
		if (pending != 0) begin
			$display("%0d expected output bytes never came out", pending);
		end
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ files.f @@
rtl/sfe_pkg.sv
rtl/sfe_calc.sv
rtl/serial_frame_encoder_crc_xor.sv
test/frame_stream_checker.sv
test/tb_serial_frame_encoder_crc_xor.sv
